// ===== hw/rtl/icc_pkg.sv =====
// Package for the import name category counter.
// Holds field widths, category codes and the fixed pattern table with its compare function.
// No dependencies.
`timescale 1ns / 1ps

package icc_pkg;

    localparam int CharBits    = 8;
    localparam int CatBits     = 4;
    localparam int CountW      = 16;
    localparam int NumCats     = 12;
    localparam int NumPats     = 49;
    localparam int MaxPatLen   = 25;
    localparam int PatBits     = MaxPatLen * CharBits;
    localparam int WindowLenDef = 25;
    localparam int CountBitsDef = 16;

    typedef enum logic [CatBits-1:0] {
        CatInjection = 4'd0,
        CatAntidebug = 4'd1,
        CatNetwork   = 4'd2,
        CatDownload  = 4'd3,
        CatProcess   = 4'd4,
        CatService   = 4'd5,
        CatRegistry  = 4'd6,
        CatFile      = 4'd7,
        CatCrypto    = 4'd8,
        CatShell     = 4'd9,
        CatMemory    = 4'd10,
        CatIpc       = 4'd11
    } t_cat;

    // Patterns are right-aligned: the last character sits in the low byte, unused bytes are zero.
    localparam logic [PatBits-1:0] PatText [NumPats] = '{
        "WriteProcessMemory", "VirtualAllocEx", "CreateRemoteThread", "SetWindowsHookEx",
        "Debugger", "DebugActiveProcess", "NtQueryInformationProcess", "OutputDebugString",
        "socket", "connect", "WSA", "Internet", "WinHttp", "HttpSend",
        "URLDownload", "InternetReadFile", "WinHttpReadData", "BITS",
        "CreateProcess", "OpenProcess", "TerminateProcess", "Process32",
        "CreateService", "OpenSCManager", "StartService",
        "RegOpen", "RegCreate", "RegSet", "RegQuery", "RegDelete",
        "CreateFile", "ReadFile", "WriteFile", "DeleteFile", "FindFirstFile",
        "Crypt", "BCrypt", "NCrypt",
        "ShellExecute", "WinExec", "CreateProcess",
        "VirtualAlloc", "VirtualProtect", "MapViewOfFile", "HeapAlloc",
        "CreateMutex", "CreateEvent", "CreatePipe", "MapViewOfFile"
    };

    localparam t_cat PatCat [NumPats] = '{
        CatInjection, CatInjection, CatInjection, CatInjection,
        CatAntidebug, CatAntidebug, CatAntidebug, CatAntidebug,
        CatNetwork, CatNetwork, CatNetwork, CatNetwork, CatNetwork, CatNetwork,
        CatDownload, CatDownload, CatDownload, CatDownload,
        CatProcess, CatProcess, CatProcess, CatProcess,
        CatService, CatService, CatService,
        CatRegistry, CatRegistry, CatRegistry, CatRegistry, CatRegistry,
        CatFile, CatFile, CatFile, CatFile, CatFile,
        CatCrypto, CatCrypto, CatCrypto,
        CatShell, CatShell, CatShell,
        CatMemory, CatMemory, CatMemory, CatMemory,
        CatIpc, CatIpc, CatIpc, CatIpc
    };

    // Compares the newest bytes of the window with every pattern; bit k is set when
    // any pattern of category k ends at the newest byte.
    function automatic logic [NumCats-1:0] pattern_hits(input logic [PatBits-1:0] tail);
        logic [NumCats-1:0] hits;
        logic [PatBits-1:0] care;
        hits = '0;
        for (int p = 0; p < NumPats; p++) begin
            for (int b = 0; b < MaxPatLen; b++) begin
                care[b*CharBits +: CharBits] =
                    (PatText[p][b*CharBits +: CharBits] != '0) ? {CharBits{1'b1}} : '0;
            end
            if (((tail ^ PatText[p]) & care) == '0) begin
                hits[PatCat[p]] = 1'b1;
            end
        end
        return hits;
    endfunction

endpackage

// ===== hw/rtl/icc_in_if.sv =====
// Input channel of the import name category counter: one name byte per transaction.
// Depends on icc_pkg for field widths.
`timescale 1ns / 1ps

interface icc_in_if import icc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CharBits-1:0] name_char;
    logic                end_of_name;
    logic                end_of_list;

    modport source (output valid, output name_char, output end_of_name, output end_of_list,
                    input ready);
    modport sink   (input valid, input name_char, input end_of_name, input end_of_list,
                    output ready);
endinterface

// ===== hw/rtl/icc_out_if.sv =====
// Output channel of the import name category counter: one category count per transaction.
// Depends on icc_pkg for field widths.
`timescale 1ns / 1ps

interface icc_out_if import icc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CatBits-1:0] category;
    logic [CountW-1:0]  category_count;
    logic               last_of_run;

    modport source (output valid, output category, output category_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input category, input category_count, input last_of_run,
                    output ready);
endinterface

// ===== hw/rtl/import_name_category_counter.sv =====
// A byte is registered into the window and compared there; an end-of-list byte then loads the
// count snapshot for the output, and the twelve counts follow one per cycle while accepted.
// Bytes are taken one per cycle, but a list end waits only while the previous list's counts are
// still being drained. The window compare sits between the window register and the counters.
// Reset (synchronous, active low) clears hit mask, counters, output state; arms the window clear.
// Depends on icc_pkg, icc_in_if and icc_out_if.
`timescale 1ns / 1ps

module import_name_category_counter import icc_pkg::*; #(
    parameter int WINDOW_LEN = WindowLenDef,
    parameter int COUNT_BITS = CountBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    icc_in_if.sink    i_in,
    icc_out_if.source o_out
);

    localparam int WinBits = WINDOW_LEN * CharBits;
    localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

    logic [WinBits-1:0]    r_win;
    logic                  r_clr;
    logic                  r_v1;
    logic                  r_eon1;
    logic                  r_eol1;
    logic [NumCats-1:0]    r_mask;
    logic [COUNT_BITS-1:0] r_cnt  [NumCats];
    logic [COUNT_BITS-1:0] r_snap [NumCats];
    logic                  r_busy;
    logic [CatBits-1:0]    r_idx;

    logic [WinBits-1:0]    n_win;
    logic [NumCats-1:0]    n_mask;
    logic [COUNT_BITS-1:0] n_cnt [NumCats];
    logic                  in_fire;
    logic                  out_fire;
    logic                  snap_free;
    logic                  stall_b;
    logic                  b_go;
    logic                  snap_load;
    logic                  last_pop;

    assign last_pop  = out_fire && (r_idx == CatIpc);
    assign snap_free = !r_busy || last_pop;
    assign stall_b   = r_v1 && r_eon1 && r_eol1 && !snap_free;
    assign b_go      = r_v1 && !stall_b;
    assign snap_load = b_go && r_eon1 && r_eol1;

    assign i_in.ready = !stall_b;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    assign o_out.valid          = r_busy;
    assign o_out.category       = r_idx;
    assign o_out.category_count = CountW'(r_snap[r_idx]);
    assign o_out.last_of_run    = (r_idx == CatIpc);

    always_comb begin
        n_win  = {(r_clr ? '0 : r_win[WinBits-CharBits-1:0]), i_in.name_char};
        n_mask = r_mask | pattern_hits(r_win[PatBits-1:0]);
        for (int k = 0; k < NumCats; k++) begin
            n_cnt[k] = (n_mask[k] && (r_cnt[k] != CntMax)) ? r_cnt[k] + 1'b1 : r_cnt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_v1   <= 1'b0;
            r_mask <= '0;
            r_busy <= 1'b0;
            r_idx  <= '0;
            for (int k = 0; k < NumCats; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (in_fire) begin
                r_win  <= n_win;
                r_clr  <= i_in.end_of_name;
                r_eon1 <= i_in.end_of_name;
                r_eol1 <= i_in.end_of_list;
                r_v1   <= 1'b1;
            end else if (b_go) begin
                r_v1 <= 1'b0;
            end

            if (b_go) begin
                if (r_eon1) begin
                    r_mask <= '0;
                    for (int k = 0; k < NumCats; k++) begin
                        r_cnt[k] <= r_eol1 ? '0 : n_cnt[k];
                    end
                end else begin
                    r_mask <= n_mask;
                end
            end

            if (snap_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                for (int k = 0; k < NumCats; k++) begin
                    r_snap[k] <= n_cnt[k];
                end
            end else if (out_fire) begin
                if (last_pop) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // The emitter never runs past the last category.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= CatIpc))
        else $error("Result index beyond the last category.");

    // A list end loads a fresh run of counts starting at the first category.
    a_snap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap_load |=> (r_busy && (r_idx == CatInjection)))
        else $error("Count run did not start after a list end.");

    // The last count drains the run unless a new list end reloads it.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last_pop && !snap_load) |=> !r_busy)
        else $error("Count run still busy after its last transaction.");

    // A name end clears the hit mask for the next name.
    a_mask_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && r_eon1) |=> (r_mask == '0))
        else $error("Hit mask not cleared at the end of a name.");

    // A list end never overwrites counts that are still being delivered.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !last_pop) |-> !snap_load)
        else $error("Count run overwritten before it was drained.");

endmodule

// ===== bench/icc_tally_monitor.sv =====
// Monitor for the import name category counter: watches both channels, predicts the counts.
// Keeps its own pattern table, window, hit mask and counters; depends on icc_pkg and both interfaces.
`timescale 1ns / 1ps

module icc_tally_monitor import icc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    icc_in_if    i_in_mon,
    icc_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int WinLen   = WindowLenDef;
    localparam int PatCount = 49;
    localparam int GroupLen [NumCats] = '{4, 4, 6, 4, 4, 3, 5, 5, 3, 3, 4, 4};

    typedef struct packed {
        t_cat              cat;
        logic [CountW-1:0] count;
        logic              last;
    } tally_t;

    string               pat_text [PatCount];
    int                  pat_cat  [PatCount];
    logic [CharBits-1:0] window [WinLen];
    logic [NumCats-1:0]  name_hits;
    logic [CountW-1:0]   cat_tally [NumCats];
    tally_t              tally_q [$];
    int                  mismatches = 0;

    initial begin
        int idx;
        pat_text = '{
            "WriteProcessMemory", "VirtualAllocEx", "CreateRemoteThread", "SetWindowsHookEx",
            "Debugger", "DebugActiveProcess", "NtQueryInformationProcess", "OutputDebugString",
            "socket", "connect", "WSA", "Internet", "WinHttp", "HttpSend",
            "URLDownload", "InternetReadFile", "WinHttpReadData", "BITS",
            "CreateProcess", "OpenProcess", "TerminateProcess", "Process32",
            "CreateService", "OpenSCManager", "StartService",
            "RegOpen", "RegCreate", "RegSet", "RegQuery", "RegDelete",
            "CreateFile", "ReadFile", "WriteFile", "DeleteFile", "FindFirstFile",
            "Crypt", "BCrypt", "NCrypt",
            "ShellExecute", "WinExec", "CreateProcess",
            "VirtualAlloc", "VirtualProtect", "MapViewOfFile", "HeapAlloc",
            "CreateMutex", "CreateEvent", "CreatePipe", "MapViewOfFile"
        };
        idx = 0;
        for (int k = 0; k < NumCats; k++) begin
            for (int j = 0; j < GroupLen[k]; j++) begin
                pat_cat[idx] = k;
                idx++;
            end
        end
    end

    function automatic logic tail_hit(input string pat);
        int n;
        n = pat.len();
        if (n == 0 || n > WinLen) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (window[WinLen - n + i] != pat[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        tally_t want;
        tally_t entry;
        if (!i_rst_n) begin
            for (int i = 0; i < WinLen; i++) begin
                window[i] = '0;
            end
            for (int k = 0; k < NumCats; k++) begin
                cat_tally[k] = '0;
            end
            name_hits = '0;
            tally_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (tally_q.size() == 0) begin
                    flag_mismatch($sformatf("count transaction for category %0d with none expected",
                                            i_out_mon.category));
                end else begin
                    want = tally_q.pop_front();
                    if (i_out_mon.category !== want.cat) begin
                        flag_mismatch($sformatf("category %0d, expected %0d",
                                                i_out_mon.category, want.cat));
                    end
                    if (i_out_mon.category_count !== want.count) begin
                        flag_mismatch($sformatf("category %0d count %0d, expected %0d",
                                                want.cat, i_out_mon.category_count, want.count));
                    end
                    if (i_out_mon.last_of_run !== want.last) begin
                        flag_mismatch($sformatf("category %0d last flag %b, expected %b",
                                                want.cat, i_out_mon.last_of_run, want.last));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                for (int i = 0; i < WinLen - 1; i++) begin
                    window[i] = window[i + 1];
                end
                window[WinLen - 1] = i_in_mon.name_char;
                for (int p = 0; p < PatCount; p++) begin
                    if (tail_hit(pat_text[p])) begin
                        name_hits[pat_cat[p]] = 1'b1;
                    end
                end
                if (i_in_mon.end_of_name) begin
                    for (int k = 0; k < NumCats; k++) begin
                        if (name_hits[k] && cat_tally[k] != {CountW{1'b1}}) begin
                            cat_tally[k] = cat_tally[k] + 1'b1;
                        end
                    end
                    for (int i = 0; i < WinLen; i++) begin
                        window[i] = '0;
                    end
                    name_hits = '0;
                    if (i_in_mon.end_of_list) begin
                        for (int k = 0; k < NumCats; k++) begin
                            entry.cat   = t_cat'(k);
                            entry.count = cat_tally[k];
                            entry.last  = (k == NumCats - 1);
                            tally_q.push_back(entry);
                            cat_tally[k] = '0;
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= tally_q.size();
    end

endmodule

// ===== bench/import_name_category_counter_tb.sv =====
// Testbench top for the import name category counter: clock, reset, name stimulus and verdict.
// Depends on icc_pkg, icc_in_if, icc_out_if, the block and icc_tally_monitor.
`timescale 1ns / 1ps

module import_name_category_counter_tb;
    import icc_pkg::*;

    localparam int CycleLimit  = 2_000_000;
    localparam int HoldCycles  = 200;
    localparam int DrainCycles = 20;
    localparam int RandomBytes = 60;

    logic                i_clk;
    logic                i_rst_n;
    logic                calm;
    int                  hold_requested = 0;
    int                  hold_served    = 0;
    int                  cycle_count    = 0;
    int                  fail_count;
    int                  pending;
    logic [CharBits-1:0] name_buf [$];

    icc_in_if  in_ch ();
    icc_out_if out_ch ();

    import_name_category_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    icc_tally_monitor u_tally_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : receiver
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requested) begin
                hold_served++;
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    task automatic send_byte(input logic [CharBits-1:0] ch, input logic eon, input logic eol);
        while (!calm && $urandom_range(99) < 12) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.name_char   <= ch;
        in_ch.end_of_name <= eon;
        in_ch.end_of_list <= eol;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // A list marker on a byte other than the last one of a name must be ignored.
    task automatic send_name(input logic list_end, input int stray_at);
        int last;
        last = name_buf.size() - 1;
        for (int i = 0; i <= last; i++) begin
            send_byte(name_buf[i], i == last, (i == last) ? list_end : (i == stray_at));
        end
        name_buf.delete();
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            name_buf.push_back(s[i]);
        end
    endtask

    task automatic append_pattern(input int p);
        logic [CharBits-1:0] c;
        for (int b = MaxPatLen - 1; b >= 0; b--) begin
            c = PatText[p][b*CharBits +: CharBits];
            if (c != '0) begin
                name_buf.push_back(c);
            end
        end
    endtask

    task automatic append_letters(input int n);
        repeat (n) name_buf.push_back(8'($urandom_range(25) + ($urandom_range(1) ? 97 : 65)));
    endtask

    initial begin : stimulus
        int names_in_list;
        int kind;
        int flip;
        int random_sent;
        i_rst_n           = 1'b0;
        calm              = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.name_char   = '0;
        in_ch.end_of_name = 1'b0;
        in_ch.end_of_list = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        name_buf.push_back(8'hFF);
        send_name(1'b0, -1);
        append_text("MapViewOfFile");
        send_name(1'b0, 0);
        append_text("WSAWSA");
        send_name(1'b1, -1);
        name_buf.push_back(8'h00);
        send_name(1'b1, -1);

        // Several short lists while the receiver holds off, so the count drain backs up.
        hold_requested++;
        repeat (4) begin
            append_text("WSA");
            send_name(1'b1, -1);
        end

        random_sent = 0;
        while (random_sent < RandomBytes) begin
            calm = (random_sent < 35);
            names_in_list = $urandom_range(1, 4);
            for (int n = 0; n < names_in_list; n++) begin
                kind = $urandom_range(99);
                if (kind < 20) begin
                    repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(255)));
                end else begin
                    append_letters($urandom_range(2));
                    append_pattern($urandom_range(NumPats - 1));
                    if (kind >= 85) begin
                        append_pattern($urandom_range(NumPats - 1));
                    end else if (kind >= 75) begin
                        flip = $urandom_range(name_buf.size() - 1);
                        name_buf[flip] = name_buf[flip] ^ 8'h20;
                    end
                    append_letters($urandom_range(2));
                end
                random_sent += name_buf.size();
                send_name(n == names_in_list - 1, $urandom_range(3 * name_buf.size()));
            end
        end

        calm = 1'b0;
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
